>>> rtl/core/vsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_pkg: shared types, constants and helpers for the scroll register unit
// Request formats, raster constants, register codes and the scroll address
// step functions used by the timing and scroll logic.
// ----------------------------------------------------------------------------
package vsr_pkg;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // Raster geometry: 341 dots by 262 lines
  localparam logic [8:0] DOT_LAST       = 9'd340;
  localparam logic [8:0] LINE_LAST      = 9'd261;
  localparam logic [8:0] LINE_RESET     = 9'd261;
  localparam logic [8:0] LINE_VISIBLE   = 9'd240;
  localparam logic [8:0] LINE_VBLANK    = 9'd241;
  localparam logic [8:0] DOT_FETCH_LAST = 9'd256;
  localparam logic [8:0] DOT_HCOPY      = 9'd257;
  localparam logic [8:0] DOT_VCOPY_LO   = 9'd280;
  localparam logic [8:0] DOT_VCOPY_HI   = 9'd304;

  // Scroll address masks
  localparam logic [14:0] HORIZ_MASK   = 15'h041F;
  localparam logic [14:0] VERT_MASK    = 15'h7BE0;
  localparam logic [14:0] COARSE_X     = 15'h001F;
  localparam logic [14:0] NT_X_BIT     = 15'h0400;
  localparam logic [14:0] NT_Y_BIT     = 15'h0800;
  localparam logic [14:0] FINE_Y_STEP  = 15'h1000;
  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [4:0]  ROW_LAST_VIS = 5'd29;
  localparam logic [4:0]  ROW_MAX      = 5'd31;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] vram_read_data;
    logic [7:0] oam_read_data;
    logic       sprite_zero_event;
    logic       overflow_event;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] vram_addr;
    logic        vram_write;
    logic [7:0]  oam_addr_out;
    logic        oam_write;
    logic [7:0]  store_data;
    logic        nmi_pulse;
    logic [8:0]  scanline_now;
    logic [8:0]  dot_now;
  } out_item_t;

  // Raster position and decoded timing windows
  typedef struct packed {
    logic [8:0] dot;
    logic [8:0] line;
    logic       visible_line;
    logic       pre_line;
    logic       frame_start;
    logic       vblank_start;
    logic       fetch_dot;
    logic       dot_256;
    logic       dot_257;
    logic       vcopy_dot;
  } pos_t;

  function automatic logic [14:0] copy_bits(input logic [14:0] cur,
                                            input logic [14:0] tmp,
                                            input logic [14:0] mask);
    copy_bits = (cur & ~mask) | (tmp & mask);
  endfunction

  // Coarse X step with horizontal nametable wrap
  function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
    if (a[4:0] == 5'h1F) begin
      step_coarse_x = (a & ~COARSE_X) ^ NT_X_BIT;
    end else begin
      step_coarse_x = a + 15'd1;
    end
  endfunction

  // Fine Y step, carrying into coarse Y with vertical nametable wrap
  function automatic logic [14:0] step_y(input logic [14:0] a);
    logic [14:0] r;
    if (a[14:12] != 3'h7) begin
      r = a + FINE_Y_STEP;
    end else begin
      r = a;
      r[14:12] = 3'h0;
      if (a[9:5] == ROW_LAST_VIS) begin
        r[9:5] = 5'd0;
        r = r ^ NT_Y_BIT;
      end else if (a[9:5] == ROW_MAX) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = a[9:5] + 5'd1;
      end
    end
    step_y = r;
  endfunction

endpackage

>>> rtl/core/vsr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_ifs: request and result channels
// Valid/ready channels carrying one request or one result item.
// ----------------------------------------------------------------------------
interface vsr_in_if import vsr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vsr_out_if import vsr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/vsr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_in_stage: request input register
// Captures one request per cycle while its slot is free or draining; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module vsr_in_stage import vsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vsr_in_if.sink     in_chan,
  input  logic       take,
  output logic       req_valid,
  output in_item_t   req_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  // Free slot or slot draining this cycle
  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;
  assign valid_nxt     = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_chan.data;
    end
  end

  assign req_valid = valid_r;
  assign req_item  = item_r;

endmodule

>>> rtl/core/vsr_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_timing: dot and scanline counter
// 341 x 262 raster counter advanced by dot ticks, with window decode.
// ----------------------------------------------------------------------------
module vsr_timing import vsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic tick,
  output pos_t pos
);

  logic [8:0] dot_r, dot_nxt;
  logic [8:0] line_r, line_nxt;

  // Counter advance with wrap at end of line and frame
  always_comb begin
    dot_nxt  = dot_r;
    line_nxt = line_r;
    if (tick) begin
      if (dot_r == DOT_LAST) begin
        dot_nxt  = 9'd0;
        line_nxt = (line_r == LINE_LAST) ? 9'd0 : line_r + 9'd1;
      end else begin
        dot_nxt = dot_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= 9'd0;
      line_r <= LINE_RESET;
    end else begin
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
    end
  end

  // Window decode
  always_comb begin
    pos.dot          = dot_r;
    pos.line         = line_r;
    pos.visible_line = line_r < LINE_VISIBLE;
    pos.pre_line     = line_r == LINE_LAST;
    pos.frame_start  = (line_r == LINE_LAST) && (dot_r == 9'd0);
    pos.vblank_start = (line_r == LINE_VBLANK) && (dot_r == 9'd0);
    pos.fetch_dot    = (dot_r != 9'd0) && (dot_r <= DOT_FETCH_LAST);
    pos.dot_256      = dot_r == DOT_FETCH_LAST;
    pos.dot_257      = dot_r == DOT_HCOPY;
    pos.vcopy_dot    = (dot_r >= DOT_VCOPY_LO) && (dot_r <= DOT_VCOPY_HI);
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dot_r <= DOT_LAST) && (line_r <= LINE_LAST))
    else $error("raster position out of range");

  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    tick && (dot_r == DOT_LAST) |=> (dot_r == 9'd0) && (line_r != $past(line_r)))
    else $error("line did not advance at end of line");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(dot_r) && $stable(line_r))
    else $error("raster moved without a tick");
`endif

endmodule

>>> rtl/core/vsr_scroll_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_scroll_core: scroll address, register file and status flags
// Applies one request to the scroll state and forms its result item.
// ----------------------------------------------------------------------------
module vsr_scroll_core import vsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  pos_t      pos,
  output out_item_t res
);

  logic        show_bg_r, show_bg_nxt;
  logic        show_spr_r, show_spr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        second_write_r, second_write_nxt;
  logic [14:0] cur_r, cur_nxt;
  logic [14:0] tmp_r, tmp_nxt;
  logic        step_row_r, step_row_nxt;
  logic [7:0]  buf_r, buf_nxt;
  logic        sz_r, sz_nxt;
  logic        ov_r, ov_nxt;
  logic        vblank_r, vblank_nxt;
  logic        nmi_en_r, nmi_en_nxt;
  logic [7:0]  spr_addr_r, spr_addr_nxt;

  logic        render_on;
  logic        cx_hit;
  logic [14:0] addr_inc;
  logic [14:0] tick_addr;
  logic [7:0]  d;

  assign d         = item.write_data;
  assign render_on = show_bg_r || show_spr_r;
  assign cx_hit    = 3'(fine_x_r + pos.dot[2:0] - 3'd1) == 3'd7;
  assign addr_inc  = step_row_r ? 15'd32 : 15'd1;

  // Scroll address update over one dot
  always_comb begin
    tick_addr = cur_r;
    if (pos.pre_line && render_on) begin
      if (pos.dot_257) tick_addr = copy_bits(tick_addr, tmp_r, HORIZ_MASK);
      if (pos.vcopy_dot) tick_addr = copy_bits(tick_addr, tmp_r, VERT_MASK);
    end
    if (pos.visible_line) begin
      if (pos.fetch_dot && show_bg_r && cx_hit) tick_addr = step_coarse_x(tick_addr);
      if (pos.dot_256 && render_on) tick_addr = step_y(tick_addr);
      if (pos.dot_257 && render_on) tick_addr = copy_bits(tick_addr, tmp_r, HORIZ_MASK);
    end
  end

  // Request decode, next state and result
  always_comb begin
    show_bg_nxt      = show_bg_r;
    show_spr_nxt     = show_spr_r;
    fine_x_nxt       = fine_x_r;
    second_write_nxt = second_write_r;
    cur_nxt          = cur_r;
    tmp_nxt          = tmp_r;
    step_row_nxt     = step_row_r;
    buf_nxt          = buf_r;
    sz_nxt           = sz_r;
    ov_nxt           = ov_r;
    vblank_nxt       = vblank_r;
    nmi_en_nxt       = nmi_en_r;
    spr_addr_nxt     = spr_addr_r;

    res              = '0;
    res.vram_addr    = cur_r[13:0];
    res.scanline_now = pos.line;
    res.dot_now      = pos.dot;

    unique case (item.operation)
      OP_TICK: begin
        if (pos.frame_start) begin
          sz_nxt     = 1'b0;
          ov_nxt     = 1'b0;
          vblank_nxt = 1'b0;
        end
        if (item.sprite_zero_event) sz_nxt = 1'b1;
        if (item.overflow_event) ov_nxt = 1'b1;
        if (pos.vblank_start) begin
          vblank_nxt    = 1'b1;
          res.nmi_pulse = nmi_en_r;
        end
        cur_nxt = tick_addr;
      end
      OP_WRITE: begin
        unique case (item.reg_index)
          REG_CTRL: begin
            tmp_nxt[11:10] = d[1:0];
            step_row_nxt   = d[2];
            nmi_en_nxt     = d[7];
          end
          REG_MASK: begin
            show_bg_nxt  = d[3];
            show_spr_nxt = d[4];
          end
          REG_OAMADDR: spr_addr_nxt = d;
          REG_OAMDATA: begin
            res.oam_addr_out = spr_addr_r;
            res.oam_write    = 1'b1;
            res.store_data   = d;
            spr_addr_nxt     = spr_addr_r + 8'd1;
          end
          REG_SCROLL: begin
            if (!second_write_r) begin
              tmp_nxt[4:0]     = d[7:3];
              fine_x_nxt       = d[2:0];
              second_write_nxt = 1'b1;
            end else begin
              tmp_nxt[14:12]   = d[2:0];
              tmp_nxt[9:5]     = d[7:3];
              second_write_nxt = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!second_write_r) begin
              tmp_nxt[14:8]    = {1'b0, d[5:0]};
              second_write_nxt = 1'b1;
            end else begin
              tmp_nxt[7:0]     = d;
              cur_nxt          = {tmp_r[14:8], d};
              second_write_nxt = 1'b0;
            end
          end
          REG_DATA: begin
            res.vram_write = 1'b1;
            res.store_data = d;
            cur_nxt        = cur_r + addr_inc;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        unique case (item.reg_index)
          REG_STATUS: begin
            res.read_data    = {vblank_r, sz_r, ov_r, 5'd0};
            vblank_nxt       = 1'b0;
            second_write_nxt = 1'b0;
          end
          REG_OAMDATA: begin
            res.read_data    = item.oam_read_data;
            res.oam_addr_out = spr_addr_r;
            spr_addr_nxt     = spr_addr_r + 8'd1;
          end
          REG_DATA: begin
            // palette range bypasses the read buffer
            if (cur_r[13:0] < PALETTE_BASE) begin
              res.read_data = buf_r;
              buf_nxt       = item.vram_read_data;
            end else begin
              res.read_data = item.vram_read_data;
            end
            cur_nxt = cur_r + addr_inc;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State registers, updated once per processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_bg_r      <= 1'b0;
      show_spr_r     <= 1'b0;
      fine_x_r       <= 3'd0;
      second_write_r <= 1'b0;
      cur_r          <= 15'd0;
      tmp_r          <= 15'd0;
      step_row_r     <= 1'b0;
      buf_r          <= 8'd0;
      sz_r           <= 1'b0;
      ov_r           <= 1'b0;
      vblank_r       <= 1'b1;
      nmi_en_r       <= 1'b0;
      spr_addr_r     <= 8'd0;
    end else if (step) begin
      show_bg_r      <= show_bg_nxt;
      show_spr_r     <= show_spr_nxt;
      fine_x_r       <= fine_x_nxt;
      second_write_r <= second_write_nxt;
      cur_r          <= cur_nxt;
      tmp_r          <= tmp_nxt;
      step_row_r     <= step_row_nxt;
      buf_r          <= buf_nxt;
      sz_r           <= sz_nxt;
      ov_r           <= ov_nxt;
      vblank_r       <= vblank_nxt;
      nmi_en_r       <= nmi_en_nxt;
      spr_addr_r     <= spr_addr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_nmi_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.nmi_pulse |=> vblank_r)
    else $error("nmi raised without vblank set");

  a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && (item.operation == OP_READ) && (item.reg_index == REG_STATUS)
    |=> !vblank_r && !second_write_r)
    else $error("status read did not clear vblank and toggle");

  a_data_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vram_write |=> cur_r == 15'($past(cur_r) + $past(addr_inc)))
    else $error("data write did not step the address");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cur_r) && $stable(tmp_r) && $stable(spr_addr_r))
    else $error("scroll state changed without a request");
`endif

endmodule

>>> rtl/core/vsr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_out_stage: result register
// Holds one result until taken; accepts a new one in the cycle it drains.
// ----------------------------------------------------------------------------
module vsr_out_stage import vsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t res,
  output logic      can_load,
  vsr_out_if.source out_chan
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load  = !valid_r || out_chan.ready;
  assign valid_nxt = load || (valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

  assign out_chan.valid = valid_r;
  assign out_chan.data  = item_r;

endmodule

>>> rtl/core/video_scroll_register_timing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scroll_register_timing_unit: scroll registers and dot timing
// Top level: request register, raster counter, scroll core, result register.
// ----------------------------------------------------------------------------
// Each request (dot tick, register write or register read) produces exactly
// one result. The unit takes one request per clock while the result register
// is not stalled. A request is captured in the input register at the edge
// that accepts it, passes through the scroll and flag logic, and lands in the
// result register when that register is free or draining. The result is
// offered from the result register. A stalled result register holds the
// pipeline, and new requests are taken again in the same cycle the pending
// result is read out.
module video_scroll_register_timing_unit import vsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vsr_in_if.sink    in_chan,
  vsr_out_if.source out_chan
);

  logic      req_valid;
  in_item_t  req_item;
  logic      out_can_load;
  logic      advance;
  logic      tick;
  pos_t      pos;
  out_item_t res;

  // Request moves to the result register when that register is free or draining
  assign advance = req_valid && out_can_load;
  assign tick    = advance && (req_item.operation == OP_TICK);

  vsr_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .take      (advance),
    .req_valid (req_valid),
    .req_item  (req_item)
  );

  vsr_timing u_timing (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .pos   (pos)
  );

  vsr_scroll_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (req_item),
    .pos   (pos),
    .res   (res)
  );

  vsr_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .res      (res),
    .can_load (out_can_load),
    .out_chan (out_chan)
  );

endmodule
